FILE: rtl/streaming_insertion_sorter_assert.svh
// Assertion macros shared by the sorter RTL.
`ifndef STREAMING_INSERTION_SORTER_ASSERT_SVH
`define STREAMING_INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorter check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define SIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorter check failed: next-cycle implication");

`endif

FILE: rtl/sis_pkg.sv
// Package: sizes and control struct for the streaming insertion sorter.
package sis_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;     // place ins_value into the sorted chain
    logic shift_out;  // move every entry one cell toward the head
  } ctrl_t;

endpackage

FILE: rtl/sis_cell.sv
// One storage cell of the sorting chain.
module sis_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  sis_pkg::ctrl_t ctrl,
  input  sis_pkg::data_t ins_value,
  input  logic           prev_gt,
  input  sis_pkg::data_t prev_value,
  input  logic           prev_valid,
  input  sis_pkg::data_t next_value,
  input  logic           next_valid,
  output logic           gt,
  output sis_pkg::data_t value,
  output logic           valid
);

  sis_pkg::data_t value_r, value_nxt;
  logic           valid_r, valid_nxt;

  // Empty cells count as greater so the new value lands at the fill edge.
  // Equal values do not count, which keeps the sort stable.
  assign gt = !valid_r || (value_r > ins_value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift_out) begin
      value_nxt = next_value;
      valid_nxt = next_valid;
    end else if (ctrl.insert && gt) begin
      if (prev_gt) begin
        value_nxt = prev_value;
        valid_nxt = prev_valid;
      end else begin
        value_nxt = ins_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

FILE: rtl/streaming_insertion_sorter.sv
// Top level: stable streaming insertion sorter built as a chain of cells.
// Insert: one value per cycle unless stalled; all cells compare in parallel,
//   so a value is placed the cycle after its transaction; the next may follow.
// Drain: the first result is valid the cycle after the marked transaction;
//   results leave one per cycle while out_stall is low; input stalls until done.
// Reset (synchronous, rst_n low): all cells empty, overflow and drain cleared.
module streaming_insertion_sorter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sis_pkg::DATA_W-1:0]  in_data_value,
  input  logic                               in_last_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sis_pkg::DATA_W-1:0]  out_sorted_value,
  output logic                               out_last_of_run,
  output logic                               out_overflowed
);

  `include "streaming_insertion_sorter_assert.svh"

  localparam int D = sis_pkg::DEPTH;

  // Chain wiring: per-cell compare result, contents and valid bit.
  logic           gt_w    [D];
  sis_pkg::data_t value_w [D];
  logic [D-1:0]   valid_vec;

  sis_pkg::ctrl_t ctrl;

  logic draining_r, draining_nxt;
  logic overflow_r, overflow_nxt;

  logic in_take;   // input transaction this cycle
  logic out_take;  // result transaction this cycle
  logic full;

  // While draining the chain holds a finished set; new input waits.
  assign in_stall = draining_r;
  assign in_take  = in_valid && !draining_r;

  // The head cell is the output register. Its valid bit gates the result.
  assign out_valid        = draining_r && valid_vec[0];
  assign out_sorted_value = value_w[0];
  assign out_last_of_run  = !valid_vec[1];
  assign out_overflowed   = overflow_r;
  assign out_take         = out_valid && !out_stall;

  // Valid entries are packed from cell 0, so the tail cell marks full.
  assign full = valid_vec[D-1];

  assign ctrl.insert    = in_take && !full;
  assign ctrl.shift_out = out_take;

  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      sis_pkg::data_t prev_value_w, next_value_w;
      logic           prev_gt_w, prev_valid_w, next_valid_w;

      if (gi == 0) begin : g_head
        // Nothing ahead of the head: a new smallest value enters here.
        assign prev_gt_w    = 1'b0;
        assign prev_value_w = in_data_value;
        assign prev_valid_w = 1'b0;
      end else begin : g_body
        assign prev_gt_w    = gt_w[gi-1];
        assign prev_value_w = value_w[gi-1];
        assign prev_valid_w = valid_vec[gi-1];
      end

      if (gi == D - 1) begin : g_tail
        // Shifting out empties the tail.
        assign next_value_w = value_w[gi];
        assign next_valid_w = 1'b0;
      end else begin : g_mid
        assign next_value_w = value_w[gi+1];
        assign next_valid_w = valid_vec[gi+1];
      end

      sis_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .ins_value  (in_data_value),
        .prev_gt    (prev_gt_w),
        .prev_value (prev_value_w),
        .prev_valid (prev_valid_w),
        .next_value (next_value_w),
        .next_valid (next_valid_w),
        .gt         (gt_w[gi]),
        .value      (value_w[gi]),
        .valid      (valid_vec[gi])
      );
    end
  endgenerate

  // Drain starts after the marked transaction (its value, if kept, is then
  // in the chain) and ends when the last result is taken.
  always_comb begin
    draining_nxt = draining_r;
    overflow_nxt = overflow_r;
    if (in_take && full) begin
      overflow_nxt = 1'b1;
    end
    if (in_take && in_last_item) begin
      draining_nxt = 1'b1;
    end
    if (out_take && out_last_of_run) begin
      draining_nxt = 1'b0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      overflow_r <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // Occupied cells always form an unbroken run from the head.
  `SIS_ASSERT_NOW(a_packed_chain, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
  // A drain never stalls on an empty head.
  `SIS_ASSERT_NOW(a_drain_nonempty, draining_r, valid_vec[0])
  // Results leave in ascending order within a set.
  `SIS_ASSERT_NEXT(a_ascending, out_take && !out_last_of_run,
                   out_valid && (out_sorted_value >= $past(out_sorted_value)))
  // After the final result the chain is empty and input resumes.
  `SIS_ASSERT_NEXT(a_run_done, out_take && out_last_of_run,
                   !in_stall && (valid_vec == '0) && !out_overflowed)

endmodule

FILE: sim/tb_streaming_insertion_sorter.sv
// Testbench for the streaming insertion sorter: random and directed sets vs. a predicted run.
`timescale 1ns / 1ps

module tb_streaming_insertion_sorter;
  typedef sis_pkg::data_t data_t;

  localparam int DEPTH       = sis_pkg::DEPTH;
  localparam int ITEM_TARGET = 410;
  localparam int IDLE_LIMIT  = 2000;   // cycles with no transaction on either side
  localparam int DRAIN_WAIT  = 40;     // settle time after the last expected result
  localparam data_t VAL_MIN  = data_t'(32'h8000_0000);
  localparam data_t VAL_MAX  = data_t'(32'h7fff_ffff);

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  // One sorted output transaction.
  typedef struct {
    data_t value;
    logic  last;
    logic  ovf;
  } sorted_result_t;

  // Scoreboard: keeps its own sorted copy of the current set and the
  // queue of results the block still owes.
  class sort_scoreboard;
    data_t          run_store[DEPTH];
    int             run_fill;
    bit             run_ovf;
    sorted_result_t expected_sorted[$];
    int             errors;

    // Accepted input transaction: insert after equal values, drop when full.
    // A marked transaction releases the whole run in ascending order.
    function void note_value(data_t v, logic last);
      int pos;
      int k;
      sorted_result_t r;
      if (run_fill >= DEPTH) begin
        run_ovf = 1'b1;
      end else begin
        pos = run_fill;
        while (pos > 0 && run_store[pos-1] > v) pos--;
        for (k = run_fill; k > pos; k--) run_store[k] = run_store[k-1];
        run_store[pos] = v;
        run_fill++;
      end
      if (last) begin
        for (k = 0; k < run_fill; k++) begin
          r.value = run_store[k];
          r.last  = (k + 1 == run_fill);
          r.ovf   = run_ovf;
          expected_sorted.push_back(r);
        end
        run_fill = 0;
        run_ovf  = 1'b0;
      end
    endfunction

    function void check_result(data_t got_value, logic got_last, logic got_ovf);
      sorted_result_t exp_r;
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected result: value %0d last %0b overflow %0b",
                 $time, got_value, got_last, got_ovf);
        errors++;
        return;
      end
      exp_r = expected_sorted.pop_front();
      if (got_value !== exp_r.value) begin
        $display("%0t: sorted value mismatch: expected %0d, got %0d",
                 $time, exp_r.value, got_value);
        errors++;
      end
      if (got_last !== exp_r.last) begin
        $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                 $time, exp_r.last, got_last);
        errors++;
      end
      if (got_ovf !== exp_r.ovf) begin
        $display("%0t: overflowed mismatch: expected %0b, got %0b",
                 $time, exp_r.ovf, got_ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected_sorted.size();
    endfunction
  endclass

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  data_t in_data_value;
  logic  in_last_item;
  logic  out_valid;
  logic  out_stall;
  data_t out_sorted_value;
  logic  out_last_of_run;
  logic  out_overflowed;

  sort_scoreboard board;
  int             items_sent;
  int             burst_left;
  int             idle_cycles;

  streaming_insertion_sorter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_value    (in_data_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_of_run  (out_last_of_run),
    .out_overflowed   (out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender side. Transactions come in bursts; between bursts valid drops
  // for a random gap. Gaps are taken before raising valid, so valid is
  // never lowered and raised in the same step. Always entered at a clock edge.
  task automatic send_item(input data_t v, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_data_value <= v;
    in_last_item  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_value(v, last);
    items_sent++;
    burst_left--;
  endtask

  // Send a set; only its final transaction carries the mark.
  task automatic send_set(input data_t vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  // Mix of extremes, tight clusters (plenty of ties) and full-range values.
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return data_t'(0);
          default: return data_t'(-1);
        endcase
      end
      1, 2, 3: return data_t'(int'($urandom_range(0, 8)) - 4);
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_random_set(input int size);
    data_t vals[$];
    repeat (size) vals.push_back(pick_value());
    send_set(vals);
  endtask

  // Result side: check every accepted result and drive out_stall from a
  // pattern that switches between free-running, light, heavy and long runs.
  initial begin : result_side
    stall_mode_t mode;
    int          mode_left;
    int          run_left;
    logic        run_stall;
    logic        stall_now;
    mode      = STALL_NONE;
    mode_left = 0;
    run_left  = 0;
    run_stall = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        board.check_result(out_sorted_value, out_last_of_run, out_overflowed);
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (mode)
        STALL_NONE:  stall_now = 1'b0;
        STALL_LIGHT: stall_now = ($urandom_range(0, 99) < 25);
        STALL_HEAVY: stall_now = ($urandom_range(0, 99) < 70);
        default: begin
          if (run_left == 0) begin
            run_stall = ~run_stall;
            run_left  = $urandom_range(1, 12);
          end
          run_left--;
          stall_now = run_stall;
        end
      endcase
      out_stall <= stall_now;
    end
  end

  // Watchdog: a run of cycles with no transaction on either channel ends the test.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_streaming_insertion_sorter: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int size;
    board      = new();
    items_sent = 0;
    burst_left = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_value <= '0;
    in_last_item  <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-value runs at both extremes, mixed extremes with
    // duplicates, ties among small values, already-sorted and reversed input.
    send_set('{VAL_MAX});
    send_set('{VAL_MIN});
    send_set('{VAL_MAX, data_t'(0), VAL_MIN, data_t'(-1), data_t'(1), VAL_MIN, VAL_MAX});
    send_set('{data_t'(5), data_t'(5), data_t'(-3), data_t'(5), data_t'(-3)});
    send_set('{data_t'(3), data_t'(2), data_t'(1), data_t'(0), data_t'(-1)});
    send_set('{data_t'(-2), data_t'(-1), data_t'(0), data_t'(1)});

    // Store exactly full, then a set that overflows so the marked value
    // itself is dropped while the run still drains.
    send_random_set(DEPTH);
    send_random_set(DEPTH + 5);

    // Random sets: mostly short, some long, a few overflowing.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       size = $urandom_range(DEPTH + 1, DEPTH + 8);
        1, 2:    size = $urandom_range(11, DEPTH);
        default: size = $urandom_range(1, 10);
      endcase
      send_random_set(size);
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.errors == 0) begin
      $display("tb_streaming_insertion_sorter: PASS");
    end else begin
      $display("tb_streaming_insertion_sorter: FAIL");
    end
    $finish;
  end

endmodule

FILE: streaming_insertion_sorter.f
+incdir+rtl
rtl/sis_pkg.sv
rtl/sis_cell.sv
rtl/streaming_insertion_sorter.sv
sim/tb_streaming_insertion_sorter.sv
